/* rtl/hec_pkg.sv */
// ---------------------------------------------------------------------------
// hec_pkg
// Shared types, entity table and lookup functions of the HTML entity codec.
// ---------------------------------------------------------------------------
package hec_pkg;

   localparam int NUM_ENT    = 25;
   localparam int ACCENT_ENT = 22;
   localparam int WINDOW     = 8;

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // register indexes
   localparam logic [7:0] REG_DIRECTION = 8'd0;
   localparam logic [7:0] REG_XML_SET   = 8'd1;

   typedef logic [4:0] ent_idx_type;

   // code-page byte of each entry
   localparam logic [7:0] ENT_CODE [NUM_ENT] = '{
      8'h85, 8'hA0, 8'h83, 8'h8A, 8'h82, 8'h88, 8'h8D, 8'hA1, 8'h8C,
      8'h95, 8'hA2, 8'h93, 8'h97, 8'hA3, 8'h96, 8'h87, 8'h81, 8'h84,
      8'h94, 8'h9A, 8'h8E, 8'h99, 8'h3C, 8'h3E, 8'h26};

   localparam logic [3:0] ENT_LEN [NUM_ENT] = '{
      4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7,
      4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd8, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5};

   // entity text, right aligned: first character in the highest used byte
   localparam logic [63:0] ENT_TEXT [NUM_ENT] = '{
      64'("&agrave;"), 64'("&aacute;"), 64'("&acirc;"),
      64'("&egrave;"), 64'("&eacute;"), 64'("&ecirc;"),
      64'("&igrave;"), 64'("&iacute;"), 64'("&icirc;"),
      64'("&ograve;"), 64'("&oacute;"), 64'("&ocirc;"),
      64'("&ugrave;"), 64'("&uacute;"), 64'("&ucirc;"),
      64'("&ccedil;"), 64'("&uuml;"),   64'("&auml;"),
      64'("&ouml;"),   64'("&Uuml;"),   64'("&Auml;"),
      64'("&Ouml;"),
      64'("&lt;"),     64'("&gt;"),     64'("&amp;")};

   typedef struct packed {
      logic        hit;
      ent_idx_type idx;
   } lookup_type;

   // one queued item with its encode classification
   typedef struct packed {
      logic [7:0] char_v;
      logic       last;
      lookup_type enc;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ENC, ST_DEC, ST_FLUSH, ST_DONE
   } back_state_type;

   // character k of entry idx
   function automatic logic [7:0] ent_char(ent_idx_type idx, logic [2:0] k);
      logic [63:0] t;
      int          sh;
      t  = ENT_TEXT[idx];
      sh = 8 * (int'(ENT_LEN[idx]) - 1 - int'(k));
      if (sh < 0) sh = 0;
      return t[sh +: 8];
   endfunction

   // byte to entry lookup; lowest index wins
   function automatic lookup_type enc_lookup(logic [7:0] c, logic xml);
      lookup_type res;
      res = '0;
      for (int i = NUM_ENT - 1; i >= 0; i--) begin
         if ((i < ACCENT_ENT || xml) && ENT_CODE[i] == c) begin
            res.hit = 1'b1;
            res.idx = ent_idx_type'(i);
         end
      end
      return res;
   endfunction

   // buffered text to entry lookup; byte k of b at [8k+:8]
   function automatic lookup_type dec_match(logic [63:0] b, logic [3:0] cnt,
                                            logic xml);
      lookup_type res;
      logic       ok;
      res = '0;
      for (int i = NUM_ENT - 1; i >= 0; i--) begin
         ok = (i < ACCENT_ENT || xml) && ENT_LEN[i] == cnt;
         for (int k = 0; k < 8; k++) begin
            if (k < int'(ENT_LEN[i]) &&
                b[8*k +: 8] != ent_char(ent_idx_type'(i), 3'(k)))
               ok = 1'b0;
         end
         if (ok) begin
            res.hit = 1'b1;
            res.idx = ent_idx_type'(i);
         end
      end
      return res;
   endfunction

endpackage

/* rtl/hec_front.sv */
// ---------------------------------------------------------------------------
// hec_front
// Accepts input items, classifies them against the entity table and holds
// them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module hec_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              xml_set,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   output logic              q_valid,
   input  logic              q_pop,
   output hec_pkg::item_type q_item
);
   import hec_pkg::*;

   item_type   mem_ff [2];
   item_type   mem_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // classify on entry
   always_comb begin
      mem_in.char_v = req_tdata;
      mem_in.last   = req_tlast;
      mem_in.enc    = enc_lookup(req_tdata, xml_set);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = mem_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   // pointers
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= mem_in;
   end

endmodule

/* rtl/hec_back.sv */
// ---------------------------------------------------------------------------
// hec_back
// Carries out queued items: entity expansion, entity buffering and rescan,
// end-of-string flush, and the result register with a one-byte hold stage
// that lets the last result of an item be marked.
// ---------------------------------------------------------------------------
module hec_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              direction,
   input  logic              xml_set,
   input  logic              buf_clear,
   input  logic              q_valid,
   output logic              q_pop,
   input  hec_pkg::item_type q_item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   import hec_pkg::*;

   back_state_type  state_ff, state_in;
   item_type        cur_ff, cur_in;
   logic [3:0]      k_ff, k_in;
   logic [7:0][7:0] buf_ff, buf_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [7:0][7:0] pend_ff, pend_in;
   logic [3:0]      pcnt_ff, pcnt_in;
   logic [7:0]      hold_ff, hold_in;
   logic            hold_v_ff, hold_v_in;
   logic [7:0]      out_ff, out_in;
   logic            out_v_ff, out_v_in;
   logic            run_ff, run_in;
   logic            strm_ff, strm_in;

   logic            out_free, stall;
   logic [7:0]      head;
   logic [7:0][7:0] nb;
   logic [3:0]      ncnt;
   logic            close, pass;
   lookup_type      m;
   logic            emit_en;
   logic [7:0]      emit_byte;
   int              s;

   assign out_free = !out_v_ff || rsp_tready;
   assign stall    = hold_v_ff && !out_free;

   // buffer append and match of the head pending byte
   always_comb begin
      head           = pend_ff[0];
      nb             = buf_ff;
      nb[cnt_ff[2:0]] = head;
      ncnt           = cnt_ff + 4'd1;
      close          = (head == CHAR_SEMI) || (ncnt == 4'(WINDOW));
      pass           = (cnt_ff == 4'd0) && (head != CHAR_AMP);
      m              = dec_match(nb, ncnt, xml_set);
   end

   // datapath and result path
   always_comb begin
      cur_in    = cur_ff;
      k_in      = k_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      run_in    = run_ff;
      strm_in   = strm_ff;
      q_pop     = 1'b0;
      emit_en   = 1'b0;
      emit_byte = '0;
      s         = 0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cur_in     = q_item;
               k_in       = 4'd0;
               pend_in[0] = q_item.char_v;
               pcnt_in    = 4'd1;
            end
         end
         ST_ENC: begin
            if (!stall) begin
               emit_en   = 1'b1;
               emit_byte = cur_ff.enc.hit ? ent_char(cur_ff.enc.idx, k_ff[2:0])
                                          : cur_ff.char_v;
               k_in      = k_ff + 4'd1;
            end
         end
         ST_DEC: begin
            if (!stall) begin
               if (pcnt_ff == 4'd0) begin
                  k_in = 4'd0;
               end else if (pass) begin
                  emit_en   = 1'b1;
                  emit_byte = head;
                  pend_in   = pend_ff >> 8;
                  pcnt_in   = pcnt_ff - 4'd1;
               end else if (!close) begin
                  buf_in  = nb;
                  cnt_in  = ncnt;
                  pend_in = pend_ff >> 8;
                  pcnt_in = pcnt_ff - 4'd1;
               end else if (m.hit) begin
                  emit_en   = 1'b1;
                  emit_byte = ENT_CODE[m.idx];
                  cnt_in    = 4'd0;
                  pend_in   = pend_ff >> 8;
                  pcnt_in   = pcnt_ff - 4'd1;
               end else begin
                  // mismatch: '&' out, rest of the buffer goes back in front
                  emit_en   = 1'b1;
                  emit_byte = CHAR_AMP;
                  cnt_in    = 4'd0;
                  for (int j = 0; j < 8; j++) begin
                     if (j < 7 && j < int'(ncnt) - 1) begin
                        pend_in[j] = nb[3'(j + 1)];
                     end else begin
                        s = j - int'(ncnt) + 2;
                        pend_in[j] = (s < 8) ? pend_ff[3'(s)] : 8'd0;
                     end
                  end
                  pcnt_in = ncnt + pcnt_ff - 4'd2;
               end
            end
         end
         ST_FLUSH: begin
            if (!stall) begin
               if (k_ff < cnt_ff) begin
                  emit_en   = 1'b1;
                  emit_byte = buf_ff[k_ff[2:0]];
                  k_in      = k_ff + 4'd1;
               end else begin
                  cnt_in = 4'd0;
               end
            end
         end
         ST_DONE: begin
            if (hold_v_ff && out_free) begin
               out_in    = hold_ff;
               out_v_in  = 1'b1;
               run_in    = 1'b1;
               strm_in   = cur_ff.last;
               hold_v_in = 1'b0;
            end
         end
         default: ;
      endcase
      // a new byte pushes the held one out as a non-final result
      if (emit_en) begin
         if (hold_v_ff) begin
            out_in   = hold_ff;
            out_v_in = 1'b1;
            run_in   = 1'b0;
            strm_in  = 1'b0;
         end
         hold_in   = emit_byte;
         hold_v_in = 1'b1;
      end
      if (buf_clear) cnt_in = 4'd0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = direction ? ST_DEC : ST_ENC;
         ST_ENC:   if (!stall && (!cur_ff.enc.hit ||
                       k_ff == ENT_LEN[cur_ff.enc.idx] - 4'd1)) state_in = ST_DONE;
         ST_DEC:   if (!stall && pcnt_ff == 4'd0)
                      state_in = cur_ff.last ? ST_FLUSH : ST_DONE;
         ST_FLUSH: if (!stall && k_ff >= cnt_ff) state_in = ST_DONE;
         ST_DONE:  if (!hold_v_ff || out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= 4'd0;
         pcnt_ff   <= 4'd0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pcnt_ff   <= pcnt_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      buf_ff  <= buf_in;
      pend_ff <= pend_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
      run_ff  <= run_in;
      strm_ff <= strm_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = run_ff;
   assign rsp_tuser  = strm_ff;

endmodule

/* rtl/html_entity_codec.sv */
// ---------------------------------------------------------------------------
// html_entity_codec
// Streaming byte codec between code-page accent bytes and HTML entities.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one text byte per item in tdata, tlast marks the string end.
//   rsp_*  : one output byte per item; tlast marks the last result caused
//            by an input item, tuser the final byte of the string.
//   csr_*  : register writes (0 direction, 1 xml_set), only while idle.
//            Writing the direction empties the entity buffer.
// Sequence: an item queues in a two-entry queue, then the back end starts
//   it from idle, processes its bytes in turn and closes it in the done
//   state. Encode: one output byte per entity character, or the plain
//   byte itself. Decode: each byte taken from the pending list (the item's
//   byte plus every byte rescanned after a failed match) is processed in
//   turn until that list is found empty, and at string end the buffered
//   bytes are flushed before the item closes; items run one at a time.
// Reset clears the queue, the buffer count, the registers and the result
//   register. When the receiver stalls, the back end carries on until the
//   result register and the one-byte hold stage are both full, then waits;
//   the queue keeps taking up to two items, then req_tready drops.
// ---------------------------------------------------------------------------
module html_entity_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser,   // stream_last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import hec_pkg::*;

   logic     direction_ff, direction_in;
   logic     xml_ff, xml_in;
   logic     csr_wr, buf_clear;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign buf_clear = csr_wr && (csr_index == REG_DIRECTION);

   // configuration registers
   always_comb begin
      direction_in = direction_ff;
      xml_in       = xml_ff;
      if (csr_wr && csr_index == REG_DIRECTION) direction_in = csr_wdata[0];
      if (csr_wr && csr_index == REG_XML_SET)   xml_in       = csr_wdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         xml_ff       <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         xml_ff       <= xml_in;
      end
   end

   hec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .xml_set    (xml_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   hec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .direction  (direction_ff),
      .xml_set    (xml_ff),
      .buf_clear  (buf_clear),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/hec_checker.sv */
// ---------------------------------------------------------------------------
// hec_checker
// Port-level checks of the codec, bound to the top level.
// ---------------------------------------------------------------------------
module hec_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // end of string only on the last result of an item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end without run end");

   // no result straight after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind html_entity_codec hec_checker u_hec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of the HTML entity codec.
// A model in the bench predicts the output bytes of each accepted item;
// a typed directed row gives its one expected byte instead. Output bytes
// are compared in order. The run starts with a short table of directed
// items, then runs random traffic under several register settings. Random
// idle cycles fall on both sides, and one long receiver hold-off stalls the input.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hec_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 24;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       str_end;
   } out_byte_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_TEXT, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      string        txt;
      logic [7:0]   a;      // byte, or register index
      logic [7:0]   b;      // end flag, or register data
      logic         typed;
      logic [7:0]   want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // typed expectation travelling with the item being offered
   logic       drv_typed = 1'b0;
   logic [7:0] drv_want = '0;

   // codec state of the model
   logic       mdl_decode = 1'b0;
   logic       mdl_xml = 1'b0;
   logic [7:0] mdl_buf [8];
   int         mdl_cnt = 0;
   out_byte_type step_out [8];
   int         step_n;

   out_byte_type pending_bytes [$];
   int  errors = 0;
   int  n_items = 0, n_results = 0, n_writes = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;

   html_entity_codec dut (.*);

   always #2 clock = ~clock;

   // ---------------- model ----------------
   function automatic logic [7:0] text_at(int e, int k);
      return ENT_TEXT[e][8 * (int'(ENT_LEN[e]) - 1 - k) +: 8];
   endfunction

   function automatic int table_entries();
      return mdl_xml ? NUM_ENT : ACCENT_ENT;
   endfunction

   function automatic void put_byte(logic [7:0] c);
      if (step_n < 8) begin
         step_out[step_n] = '{c, 1'b0, 1'b0};
         step_n++;
      end
   endfunction

   function automatic int entity_hit();
      bit same;
      for (int e = 0; e < table_entries(); e++) begin
         same = (int'(ENT_LEN[e]) == mdl_cnt);
         for (int k = 0; k < mdl_cnt && same; k++)
            if (mdl_buf[k] != text_at(e, k)) same = 1'b0;
         if (same) return e;
      end
      return -1;
   endfunction

   function automatic void encode_char(logic [7:0] c);
      for (int e = 0; e < table_entries(); e++) begin
         if (ENT_CODE[e] == c) begin
            for (int k = 0; k < int'(ENT_LEN[e]); k++) put_byte(text_at(e, k));
            return;
         end
      end
      put_byte(c);
   endfunction

   // rescans the tail of a failed entity as fresh input
   function automatic void decode_char(logic [7:0] c);
      logic [7:0] work [16];
      logic [7:0] spill [16];
      logic [7:0] b;
      int qn, idx, t, m;
      work[0] = c;
      qn = 1;
      idx = 0;
      while (idx < qn) begin
         b = work[idx];
         idx++;
         if (mdl_cnt == 0 && b != CHAR_AMP) begin
            put_byte(b);
            continue;
         end
         if (mdl_cnt < 8) begin
            mdl_buf[mdl_cnt] = b;
            mdl_cnt++;
         end
         if (b == CHAR_SEMI || mdl_cnt >= WINDOW) begin
            m = entity_hit();
            if (m >= 0) begin
               put_byte(ENT_CODE[m]);
            end else begin
               t = 0;
               put_byte(CHAR_AMP);
               for (int k = 1; k < mdl_cnt && t < 16; k++) spill[t++] = mdl_buf[k];
               for (int k = idx; k < qn && t < 16; k++) spill[t++] = work[k];
               for (int k = 0; k < t; k++) work[k] = spill[k];
               qn = t;
               idx = 0;
            end
            mdl_cnt = 0;
         end
      end
   endfunction

   function automatic void predict_item(logic [7:0] c, logic eos);
      step_n = 0;
      if (!mdl_decode) begin
         encode_char(c);
      end else begin
         decode_char(c);
         if (eos) begin
            for (int k = 0; k < mdl_cnt; k++) put_byte(mdl_buf[k]);
            mdl_cnt = 0;
         end
      end
      if (step_n > 0) begin
         step_out[step_n - 1].run_end = 1'b1;
         step_out[step_n - 1].str_end = eos;
      end
   endfunction

   task automatic report(string what, logic [7:0] got, logic [7:0] want);
      $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
      errors++;
   endtask

   // ---------------- monitor: predict on input, check on output ----------------
   always @(posedge clock) begin
      out_byte_type w;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            n_writes++;
            if (csr_index == REG_DIRECTION) begin
               mdl_decode = csr_wdata[0];
               mdl_cnt = 0;
            end else if (csr_index == REG_XML_SET) begin
               mdl_xml = csr_wdata[0];
            end
         end
         if (req_tvalid && req_tready) begin
            n_items++;
            predict_item(req_tdata, req_tlast);
            if (drv_typed) begin
               pending_bytes.push_back('{drv_want, 1'b1, req_tlast});
            end else begin
               for (int k = 0; k < step_n; k++) pending_bytes.push_back(step_out[k]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (pending_bytes.size() == 0) begin
               report("unexpected item", rsp_tdata, 8'h00);
            end else begin
               w = pending_bytes.pop_front();
               if (rsp_tdata != w.ch) report("char_out", rsp_tdata, w.ch);
               if (rsp_tlast != w.run_end)
                  report("run_last", 8'(rsp_tlast), 8'(w.run_end));
               if (rsp_tuser != w.str_end)
                  report("stream_last", 8'(rsp_tuser), 8'(w.str_end));
            end
         end
      end
   end

   // ---------------- receiver with random stalls and one long hold-off ----------------
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_req && held < HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
            held++;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   // ---------------- watchdog on cycles without any handshake ----------------
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_byte(logic [7:0] c, logic eos, logic typed, logic [7:0] want);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eos;
      drv_typed  <= typed;
      drv_want   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // registers change only once the codec has drained
   task automatic write_reg(logic [7:0] index, logic [7:0] data);
      @(negedge clock);
      req_tvalid <= 1'b0;
      drv_typed  <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_text(string s, logic eos);
      for (int k = 0; k < s.len(); k++)
         send_byte(s[k], eos && (k == s.len() - 1), 1'b0, 8'h00);
   endtask

   // one random run of bytes; decode runs are mostly entity texts
   task automatic send_random_token(bit dec);
      logic [7:0] run [$];
      int e, pick, n;
      pick = $urandom_range(0, 99);
      e = $urandom_range(0, NUM_ENT - 1);
      if (!dec) begin
         run.push_back(pick < 50 ? ENT_CODE[e] : 8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
         for (int k = 0; k < int'(ENT_LEN[e]); k++) run.push_back(text_at(e, k));
         if ($urandom_range(0, 3) == 0)
            run[$urandom_range(0, run.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 75) begin
         run.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
         run.push_back(CHAR_AMP);
         n = $urandom_range(0, 9);
         for (int k = 0; k < n; k++) run.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else begin
         run.push_back(CHAR_SEMI);
      end
      foreach (run[k])
         send_byte(run[k], (k == run.size() - 1) && ($urandom_range(0, 99) < 15),
                   1'b0, 8'h00);
   endtask

   initial begin
      row_type plan [];
      logic [1:0] settings [5];
      plan = '{
         '{ROW_REG,  "", REG_DIRECTION, 8'h00, 1'b0, 8'h00},
         '{ROW_REG,  "", REG_XML_SET,   8'h00, 1'b0, 8'h00},
         '{ROW_BYTE, "", 8'h00, 8'h00, 1'b1, 8'h00},
         '{ROW_BYTE, "", 8'hFF, 8'h00, 1'b1, 8'hFF},
         '{ROW_BYTE, "", 8'h85, 8'h00, 1'b0, 8'h00},
         '{ROW_BYTE, "", 8'h26, 8'h00, 1'b1, 8'h26},
         '{ROW_BYTE, "", 8'h3C, 8'h01, 1'b1, 8'h3C},
         '{ROW_REG,  "", REG_XML_SET,   8'hFF, 1'b0, 8'h00},
         '{ROW_BYTE, "", 8'h26, 8'h00, 1'b0, 8'h00},
         '{ROW_REG,  "", 8'h02,         8'h01, 1'b0, 8'h00},
         '{ROW_REG,  "", REG_DIRECTION, 8'hFF, 1'b0, 8'h00},
         '{ROW_TEXT, "&lt;", 8'h00, 8'h00, 1'b0, 8'h00},
         '{ROW_TEXT, "&ab;", 8'h00, 8'h00, 1'b0, 8'h00},
         '{ROW_TEXT, "&acirc", 8'h00, 8'h01, 1'b0, 8'h00},
         '{ROW_BYTE, "", 8'h00, 8'h00, 1'b1, 8'h00},
         '{ROW_TEXT, "&l", 8'h00, 8'h00, 1'b0, 8'h00},
         '{ROW_REG,  "", REG_XML_SET,   8'h00, 1'b0, 8'h00},
         '{ROW_TEXT, "t;", 8'h00, 8'h01, 1'b0, 8'h00}
      };
      // encode plain, encode xml, decode plain, decode xml, decode plain
      settings = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b01};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[r]) begin
         case (plan[r].kind)
            ROW_REG:  write_reg(plan[r].a, plan[r].b);
            ROW_BYTE: send_byte(plan[r].a, plan[r].b[0], plan[r].typed, plan[r].want);
            default:  send_text(plan[r].txt, plan[r].b[0]);
         endcase
      end

      // random phases; the first stalls the receiver, the second never idles
      // decode tokens average about five bytes, encode tokens one
      foreach (settings[p]) begin
         write_reg(REG_DIRECTION, {7'($urandom_range(0, 127)), settings[p][0]});
         write_reg(REG_XML_SET,   {7'($urandom_range(0, 127)), settings[p][1]});
         calm = (p == 1);
         hold_req = (p == 0);
         repeat (settings[p][0] ? 19 : 40) send_random_token(settings[p][0]);
         send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'h00);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d input items, %0d output bytes, %0d register writes",
               n_items, n_results, n_writes);
      $display("encode and decode with and without the xml entries, stalls on both sides");
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* html_entity_codec.f */
rtl/hec_pkg.sv
rtl/hec_front.sv
rtl/hec_back.sv
rtl/html_entity_codec.sv
rtl/hec_checker.sv
dv/testbench.sv
